### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nsc_pkg.sv
// Shared types and constants of the NMEA sentence checker.
`default_nettype none
package nsc_pkg;

	localparam int FIELD_MAX_DEF = 64;
	localparam int QDEPTH        = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int TYPE_W     = 40;
	localparam int FNUM_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SENTENCE_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_NUMBER  = 2'd1;

	localparam logic [TYPE_W-1:0] SENTENCE_TYPE_RST = 40'h4750524D43;
	localparam logic [FNUM_W-1:0] FIELD_NUMBER_RST  = 5'd1;
	localparam logic [FNUM_W-1:0] COMMA_MAX         = 5'd31;
	localparam logic [2:0]        HDR_LEN           = 3'd5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic ITEM_FIELD  = 1'b0;
	localparam logic ITEM_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       dollar;
		logic       lf;
		logic       star;
		logic       comma;
		logic       term;
		logic [3:0] hex;
	} tok_t;

	typedef struct packed {
		logic kind;
		logic [7:0] ch;
		logic ck;
		logic ty;
		logic fo;
	} res_t;

endpackage
`default_nettype wire

### rtl/nsc_front.sv
// Front end: takes received bytes and classifies them into tokens.
`default_nettype none
module nsc_front import nsc_pkg::*; (
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	input  wire logic       q_full,
	output logic            full,
	output logic            q_push,
	output tok_t            tok
);

	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [3:0] v;
		v = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			v = 4'(b[2:0] + 3'd1) + 4'd8;
		return v;
	endfunction

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		tok.data   = rx_byte;
		tok.dollar = rx_byte == CH_DOLLAR;
		tok.lf     = rx_byte == CH_LF;
		tok.star   = rx_byte == CH_STAR;
		tok.comma  = rx_byte == CH_COMMA;
		tok.term   = rx_byte == CH_COMMA || rx_byte == CH_STAR || rx_byte == CH_CR;
		tok.hex    = hex_value(rx_byte);
	end

endmodule
`default_nettype wire

### rtl/nsc_fifo.sv
// Short token queue between the front and back ends.
`default_nettype none
module nsc_fifo import nsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  tok_t      wr_tok,
	output logic      q_full,
	input  wire logic rd_en,
	output logic      rd_valid,
	output tok_t      rd_tok
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

	tok_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_full   = cnt_q == CNT_W'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_tok   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			if (rd_en) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/nsc_back.sv
// Back end: line parser, checksum, header compare, field extract, result register.
`default_nettype none
module nsc_back import nsc_pkg::*; #(
	parameter int FIELD_MAX = FIELD_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tok_valid,
	input  tok_t                       tok,
	output logic                       tok_pop,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  out_pop,
	output logic                       out_valid,
	output res_t                       res
);

	localparam int LEN_W = $clog2(FIELD_MAX + 1);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FIELD_MAX - 1);

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_SKIP  = 6'b000010,
		PH_BODY  = 6'b000100,
		PH_HEXHI = 6'b001000,
		PH_HEXLO = 6'b010000,
		PH_TAIL  = 6'b100000
	} phase_t;

	logic [TYPE_W-1:0] stype_q;
	logic [FNUM_W-1:0] fnum_q;

	phase_t            phase_q, phase_d;
	logic [7:0]        xor_q, xor_d, given_q, given_d;
	logic [2:0]        hpos_q, hpos_d;
	logic              heq_q, heq_d;
	logic [FNUM_W-1:0] cnt_q, cnt_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              ended_q, ended_d, ovf_q, ovf_d;

	logic       out_valid_q;
	res_t       res_q, res_d;
	logic       emit, do_field, take;
	logic [7:0] want;

	assign take      = tok_valid && (!out_valid_q || out_pop);
	assign tok_pop   = take;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		case (hpos_q)
			3'd0:    want = stype_q[39:32];
			3'd1:    want = stype_q[31:24];
			3'd2:    want = stype_q[23:16];
			3'd3:    want = stype_q[15:8];
			3'd4:    want = stype_q[7:0];
			default: want = 8'h00;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		given_d  = given_q;
		hpos_d   = hpos_q;
		heq_d    = heq_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		ended_d  = ended_q;
		ovf_d    = ovf_q;
		emit     = 1'b0;
		do_field = 1'b0;
		res_d    = '{kind: ITEM_FIELD, ch: tok.data, ck: 1'b0, ty: 1'b0, fo: 1'b0};
		case (phase_q)
			PH_START: begin
				if (tok.dollar) begin
					xor_d    = '0;
					given_d  = '0;
					hpos_d   = '0;
					heq_d    = 1'b1;
					cnt_d    = '0;
					len_d    = '0;
					ended_d  = 1'b0;
					ovf_d    = 1'b0;
					phase_d  = PH_BODY;
					do_field = 1'b1;
				end else if (!tok.lf) begin
					phase_d = PH_SKIP;
				end
			end
			PH_BODY, PH_HEXHI, PH_HEXLO, PH_TAIL: begin
				if (tok.lf) begin
					emit     = 1'b1;
					res_d.kind = ITEM_STATUS;
					res_d.ch   = 8'h00;
					res_d.ck   = (phase_q != PH_BODY) && (given_q == xor_q);
					res_d.ty   = (hpos_q == HDR_LEN) && heq_q;
					res_d.fo   = ended_q && !ovf_q;
					phase_d    = PH_START;
				end else begin
					if (hpos_q < HDR_LEN) begin
						if (want != tok.data) heq_d = 1'b0;
						hpos_d = hpos_q + 3'd1;
					end
					case (phase_q)
						PH_BODY: begin
							if (tok.star) phase_d = PH_HEXHI;
							else xor_d = xor_q ^ tok.data;
						end
						PH_HEXHI: begin
							given_d = {tok.hex, 4'h0};
							phase_d = PH_HEXLO;
						end
						PH_HEXLO: begin
							given_d = {given_q[7:4], tok.hex};
							phase_d = PH_TAIL;
						end
						default: ;
					endcase
					do_field = 1'b1;
				end
			end
			default: begin
				if (tok.lf) phase_d = PH_START;
			end
		endcase

		if (do_field) begin
			if (cnt_d == fnum_q && !ended_d) begin
				if (tok.term) begin
					ended_d = 1'b1;
				end else if (len_d < LEN_LIMIT) begin
					emit  = 1'b1;
					len_d = len_d + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
			end
			if (tok.comma && cnt_d < COMMA_MAX) cnt_d = cnt_d + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stype_q <= SENTENCE_TYPE_RST;
			fnum_q  <= FIELD_NUMBER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENTENCE_TYPE: stype_q <= cfg_data[TYPE_W-1:0];
				REG_FIELD_NUMBER:  fnum_q  <= cfg_data[FNUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			xor_q       <= '0;
			given_q     <= '0;
			hpos_q      <= '0;
			heq_q       <= 1'b1;
			cnt_q       <= '0;
			len_q       <= '0;
			ended_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				xor_q   <= xor_d;
				given_q <= given_d;
				hpos_q  <= hpos_d;
				heq_q   <= heq_d;
				cnt_q   <= cnt_d;
				len_q   <= len_d;
				ended_q <= ended_d;
				ovf_q   <= ovf_d;
			end
			if (take && emit) out_valid_q <= 1'b1;
			else if (out_pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) res_q <= res_d;
	end

endmodule
`default_nettype wire

### rtl/nmea_sentence_checker_unit.sv
// Top level of the NMEA sentence checker: front end, token queue, back end.
//
//   channel   handshake           payload
//   input     push / full         rx_byte
//   result    empty / pop         item_kind field_char checksum_ok type_match field_ok
//   config    cfg_valid/cfg_ready cfg_index cfg_data
//
// One byte per cycle unless pops stall; results pass the token queue and a register.
// The two-entry token queue and the one-entry result register absorb pop stalls.
// Full rises once both queue entries hold a token while the result waits unpopped.
// Reset clears the parser to line start and loads GPRMC and field 1.
// cfg_ready is always high.
`default_nettype none
module nmea_sentence_checker_unit import nsc_pkg::*; #(
	parameter int FIELD_MAX = FIELD_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            rx_byte,
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       item_kind,
	output logic [7:0]                 field_char,
	output logic                       checksum_ok,
	output logic                       type_match,
	output logic                       field_ok,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	tok_t front_tok, q_tok;
	res_t res;
	logic q_full, q_push, q_valid, q_pop, out_valid;

	assign cfg_ready = 1'b1;

	nsc_front u_front (
		.push    (push),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.full    (full),
		.q_push  (q_push),
		.tok     (front_tok)
	);

	nsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_tok   (front_tok),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_tok   (q_tok)
	);

	nsc_back #(.FIELD_MAX(FIELD_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok       (q_tok),
		.tok_pop   (q_pop),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_pop   (pop && out_valid),
		.out_valid (out_valid),
		.res       (res)
	);

	assign empty       = !out_valid;
	assign item_kind   = res.kind;
	assign field_char  = res.ch;
	assign checksum_ok = res.ck;
	assign type_match  = res.ty;
	assign field_ok    = res.fo;

endmodule
`default_nettype wire

### rtl/nsc_checker.sv
// Port-level assertions for the NMEA sentence checker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module nsc_checker import nsc_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       item_kind,
	input wire logic [7:0] field_char,
	input wire logic       checksum_ok,
	input wire logic       type_match,
	input wire logic       field_ok
);

	`ASSERT_CLK(a_status_no_char, (!empty && item_kind == ITEM_STATUS) |-> field_char == 8'h00, "status item carries a character")
	`ASSERT_CLK(a_field_no_flags, (!empty && item_kind == ITEM_FIELD) |-> (!checksum_ok && !type_match && !field_ok), "field item carries status flags")
	`ASSERT_CLK(a_field_not_delim, (!empty && item_kind == ITEM_FIELD) |-> (field_char != CH_LF && field_char != CH_COMMA && field_char != CH_STAR && field_char != CH_CR), "delimiter emitted as field byte")
	`ASSERT_CLK(a_result_holds, (!empty && !pop) |=> (!empty && $stable(item_kind) && $stable(field_char)), "waiting result changed")

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (.*);
`default_nettype wire
